// ----- design/assert_macros.svh -----
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- design/dsp_pkg.sv -----
`default_nettype none

package dsp_pkg;

  localparam int IntBitsDef     = 256;
  localparam int MaxIntBytesDef = 33;

  localparam int WordBits = 64;
  localparam int OutWords = 4;
  localparam int SnapBits = WordBits * OutWords;

  localparam logic [7:0] SeqTag    = 8'h30;
  localparam logic [7:0] IntTag    = 8'h02;
  localparam logic [8:0] HdrBytes  = 9'd4;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadHdr   = 3'd1,
    StBadMark  = 3'd2,
    StLenMis   = 3'd3,
    StTooLong  = 3'd4
  } status_e;

  typedef enum logic [7:0] {
    PhIdle   = 8'b0000_0001,
    PhTotal  = 8'b0000_0010,
    PhRMark  = 8'b0000_0100,
    PhRLen   = 8'b0000_1000,
    PhRBytes = 8'b0001_0000,
    PhSMark  = 8'b0010_0000,
    PhSLen   = 8'b0100_0000,
    PhSBytes = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic                valid;
    status_e             status;
    logic [SnapBits-1:0] r_snap;
    logic [SnapBits-1:0] s_snap;
  } dsp_result_t;

endpackage

`default_nettype wire

// ----- design/dsp_parse.sv -----
`default_nettype none

module dsp_parse #(
  parameter int INT_BITS      = dsp_pkg::IntBitsDef,
  parameter int MAX_INT_BYTES = dsp_pkg::MaxIntBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               first_i,
  output dsp_pkg::dsp_result_t    res_o
);
  import dsp_pkg::*;

  localparam int LenW    = $clog2(MAX_INT_BYTES + 1);
  localparam int ExtBits = (INT_BITS > SnapBits) ? INT_BITS : SnapBits;
  localparam logic [7:0] MaxLen = 8'(MAX_INT_BYTES);

  phase_e              phase_q, phase_d;
  logic [7:0]          total_q, total_d;
  logic [LenW-1:0]     rlen_q, rlen_d;
  logic [LenW-1:0]     slen_q, slen_d;
  logic [LenW-1:0]     cnt_q, cnt_d;
  logic [INT_BITS-1:0] racc_q, racc_d;
  logic [INT_BITS-1:0] sacc_q, sacc_d;

  logic [LenW-1:0]     cnt_inc;
  logic [INT_BITS-1:0] rshift, sshift;
  logic [8:0]          len_sum;
  logic                finish;
  logic [ExtBits-1:0]  r_ext, s_ext;

  assign cnt_inc = cnt_q + LenW'(1);
  assign rshift  = {racc_q[INT_BITS-9:0], data_byte_i};
  assign sshift  = {sacc_q[INT_BITS-9:0], data_byte_i};
  assign len_sum = 9'(rlen_q) + 9'(slen_d) + HdrBytes;
  assign r_ext   = ExtBits'(racc_q);
  assign s_ext   = ExtBits'(sacc_d);

  always_comb begin
    phase_d      = phase_q;
    total_d      = total_q;
    rlen_d       = rlen_q;
    slen_d       = slen_q;
    cnt_d        = cnt_q;
    racc_d       = racc_q;
    sacc_d       = sacc_q;
    finish       = 1'b0;
    res_o.valid  = 1'b0;
    res_o.status = StOk;
    if (fire_i) begin
      if (first_i) begin
        if (data_byte_i != SeqTag) begin
          res_o.valid  = 1'b1;
          res_o.status = StBadHdr;
          phase_d      = PhIdle;
        end else begin
          phase_d = PhTotal;
        end
      end else begin
        unique case (phase_q)
          PhIdle: ;
          PhTotal: begin
            total_d = data_byte_i;
            phase_d = PhRMark;
          end
          PhRMark, PhSMark: begin
            if (data_byte_i != IntTag) begin
              res_o.valid  = 1'b1;
              res_o.status = StBadMark;
              phase_d      = PhIdle;
            end else begin
              phase_d = (phase_q == PhRMark) ? PhRLen : PhSLen;
            end
          end
          PhRLen: begin
            if (data_byte_i > MaxLen) begin
              res_o.valid  = 1'b1;
              res_o.status = StTooLong;
              phase_d      = PhIdle;
            end else begin
              rlen_d  = data_byte_i[LenW-1:0];
              cnt_d   = '0;
              racc_d  = '0;
              phase_d = (data_byte_i == 8'd0) ? PhSMark : PhRBytes;
            end
          end
          PhRBytes: begin
            racc_d = rshift;
            cnt_d  = cnt_inc;
            if (cnt_inc >= rlen_q) phase_d = PhSMark;
          end
          PhSLen: begin
            if (data_byte_i > MaxLen) begin
              res_o.valid  = 1'b1;
              res_o.status = StTooLong;
              phase_d      = PhIdle;
            end else begin
              slen_d = data_byte_i[LenW-1:0];
              cnt_d  = '0;
              sacc_d = '0;
              if (data_byte_i == 8'd0) finish = 1'b1;
              else phase_d = PhSBytes;
            end
          end
          PhSBytes: begin
            sacc_d = sshift;
            cnt_d  = cnt_inc;
            if (cnt_inc >= slen_q) finish = 1'b1;
          end
          default: phase_d = PhIdle;
        endcase
      end
    end
    if (finish) begin
      res_o.valid  = 1'b1;
      res_o.status = ({1'b0, total_q} != len_sum) ? StLenMis : StOk;
      phase_d      = PhIdle;
    end
    res_o.r_snap = r_ext[SnapBits-1:0];
    res_o.s_snap = s_ext[SnapBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      total_q <= '0;
      rlen_q  <= '0;
      slen_q  <= '0;
      cnt_q   <= '0;
      racc_q  <= '0;
      sacc_q  <= '0;
    end else begin
      phase_q <= phase_d;
      total_q <= total_d;
      rlen_q  <= rlen_d;
      slen_q  <= slen_d;
      cnt_q   <= cnt_d;
      racc_q  <= racc_d;
      sacc_q  <= sacc_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/dsp_emit.sv -----
`default_nettype none

`include "assert_macros.svh"

module dsp_emit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dsp_pkg::dsp_result_t  res_i,
  output logic                       full_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [2:0]                 status_o,
  output logic                       which_o,
  output logic [1:0]                 word_index_o,
  output logic [dsp_pkg::WordBits-1:0] word_o,
  output logic                       last_o
);
  import dsp_pkg::*;

  dsp_result_t emit_q, pend_q;
  logic        emit_valid_q, pend_valid_q;
  logic [2:0]  idx_q;

  logic                emit_err, emit_last, out_fire, emit_free;
  logic [1:0]          widx;
  logic [SnapBits-1:0] snap;

  assign emit_err  = emit_q.status != StOk;
  assign emit_last = emit_err || (idx_q == 3'd7);
  assign out_fire  = emit_valid_q && !out_stall_i;
  assign emit_free = !emit_valid_q || (out_fire && emit_last);
  assign widx      = ~idx_q[1:0];
  assign snap      = idx_q[2] ? emit_q.s_snap : emit_q.r_snap;

  assign full_o       = pend_valid_q;
  assign out_valid_o  = emit_valid_q;
  assign status_o     = emit_q.status;
  assign which_o      = emit_err ? 1'b0 : idx_q[2];
  assign word_index_o = emit_err ? 2'd0 : widx;
  assign word_o       = emit_err ? '0 : snap[widx*WordBits +: WordBits];
  assign last_o       = emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
      idx_q        <= '0;
    end else if (emit_free) begin
      // refill from the waiting slot first to keep order
      idx_q        <= '0;
      emit_valid_q <= pend_valid_q || res_i.valid;
      pend_valid_q <= 1'b0;
    end else begin
      if (out_fire) idx_q <= idx_q + 3'd1;
      if (res_i.valid) pend_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_free) begin
      emit_q <= pend_valid_q ? pend_q : res_i;
    end else if (res_i.valid) begin
      pend_q <= res_i;
    end
  end

  `ASSERT_CHK(a_pend_behind_emit, clk_i, rst_ni, pend_valid_q |-> emit_valid_q,
              "waiting result without one in flight")
  `ASSERT_NEVER(a_no_overrun, clk_i, rst_ni, res_i.valid && pend_valid_q,
                "new result while both slots are full")
  `ASSERT_CHK(a_err_single, clk_i, rst_ni,
              (emit_valid_q && emit_err) |-> (idx_q == 3'd0),
              "error result advanced past first word")
  `ASSERT_CHK(a_words_follow, clk_i, rst_ni, (out_fire && !emit_last) |=> out_valid_o,
              "signature words interrupted")

endmodule

`default_nettype wire

// ----- design/der_signature_parser.sv -----
// Results are decoded combinationally and registered in the emit slot before they are presented.
// Throughput: one byte per cycle while in_stall_o is low; a decoded signature holds the output for
// eight transfers and an error result for one, set by the word sequencer.
// Input stalls only while one result is being sent and another waits behind it.
// Reset (async, active low) returns the parser to idle and empties both result slots.
`default_nettype none

module der_signature_parser #(
  parameter int INT_BITS      = dsp_pkg::IntBitsDef,
  parameter int MAX_INT_BYTES = dsp_pkg::MaxIntBytesDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [7:0]              data_byte_i,
  input  wire logic                    first_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [2:0]                   status_o,
  output logic                         which_o,
  output logic [1:0]                   word_index_o,
  output logic [dsp_pkg::WordBits-1:0] word_o,
  output logic                         last_o
);
  import dsp_pkg::*;

  dsp_result_t res;
  logic        full;
  logic        in_fire;

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !full;

  dsp_parse #(
    .INT_BITS      (INT_BITS),
    .MAX_INT_BYTES (MAX_INT_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .data_byte_i (data_byte_i),
    .first_i     (first_i),
    .res_o       (res)
  );

  dsp_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .full_o       (full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .which_o      (which_o),
    .word_index_o (word_index_o),
    .word_o       (word_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ----- verif/der_signature_checker.sv -----
`timescale 1ns / 1ps

module der_signature_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         first_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [2:0]                   status_i,
  input  logic                         which_i,
  input  logic [1:0]                   word_index_i,
  input  logic [dsp_pkg::WordBits-1:0] word_i,
  input  logic                         last_i,
  output int                           mismatch_count_o,
  output int                           pending_o,
  output int                           results_o,
  output int                           error_results_o
);
  import dsp_pkg::*;

  typedef struct packed {
    status_e             status;
    logic                which;
    logic [1:0]          idx;
    logic [WordBits-1:0] word;
    logic                last;
  } sig_word_t;

  sig_word_t expected_words_q[$];
  sig_word_t oldest_word;

  phase_e                phase_q   = PhIdle;
  int unsigned           total_len = 0;
  int unsigned           r_len     = 0;
  int unsigned           s_len     = 0;
  int unsigned           int_bytes = 0;
  logic [IntBitsDef-1:0] r_acc     = '0;
  logic [IntBitsDef-1:0] s_acc     = '0;

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
    results_o        = 0;
    error_results_o  = 0;
  end

  function automatic void push_error(status_e code);
    sig_word_t e;
    e.status = code;
    e.which  = 1'b0;
    e.idx    = 2'd0;
    e.word   = '0;
    e.last   = 1'b1;
    expected_words_q.push_back(e);
    phase_q = PhIdle;
  endfunction

  function automatic void close_signature();
    logic [SnapBits-1:0] r_snap;
    logic [SnapBits-1:0] s_snap;
    sig_word_t           e;
    if (total_len != r_len + s_len + HdrBytes) begin
      push_error(StLenMis);
      return;
    end
    // words past the accumulator width come out as zero
    r_snap = SnapBits'(r_acc);
    s_snap = SnapBits'(s_acc);
    for (int k = 0; k < 2; k++) begin
      for (int w = OutWords - 1; w >= 0; w--) begin
        e.status = StOk;
        e.which  = (k == 1);
        e.idx    = 2'(w);
        e.word   = (k == 1) ? s_snap[w*WordBits +: WordBits] : r_snap[w*WordBits +: WordBits];
        e.last   = (k == 1) && (w == 0);
        expected_words_q.push_back(e);
      end
    end
    phase_q = PhIdle;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic is_first);
    // a first byte always restarts, whatever was in progress
    if (is_first) begin
      if (b != SeqTag) push_error(StBadHdr);
      else phase_q = PhTotal;
      return;
    end
    case (phase_q)
      PhTotal: begin
        total_len = b;
        phase_q   = PhRMark;
      end
      PhRMark: begin
        if (b != IntTag) push_error(StBadMark);
        else phase_q = PhRLen;
      end
      PhRLen: begin
        if (b > MaxIntBytesDef) begin
          push_error(StTooLong);
        end else begin
          r_len     = b;
          int_bytes = 0;
          r_acc     = '0;
          if (b == 0) phase_q = PhSMark;
          else phase_q = PhRBytes;
        end
      end
      PhRBytes: begin
        r_acc = {r_acc[IntBitsDef-9:0], b};
        int_bytes++;
        if (int_bytes >= r_len) phase_q = PhSMark;
      end
      PhSMark: begin
        if (b != IntTag) push_error(StBadMark);
        else phase_q = PhSLen;
      end
      PhSLen: begin
        if (b > MaxIntBytesDef) begin
          push_error(StTooLong);
        end else begin
          s_len     = b;
          int_bytes = 0;
          s_acc     = '0;
          if (b == 0) close_signature();
          else phase_q = PhSBytes;
        end
      end
      PhSBytes: begin
        s_acc = {s_acc[IntBitsDef-9:0], b};
        int_bytes++;
        if (int_bytes >= s_len) close_signature();
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_words_q.delete();
      phase_q   = PhIdle;
      total_len = 0;
      r_len     = 0;
      s_len     = 0;
      int_bytes = 0;
      r_acc     = '0;
      s_acc     = '0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) decode_byte(data_byte_i, first_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_words_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: result with nothing expected: status %0d which %0d index %0d word %h",
                     $time, status_i, which_i, word_index_i, word_i);
        end else begin
          oldest_word = expected_words_q.pop_front();
          results_o++;
          if (oldest_word.status != StOk) error_results_o++;
          if (status_i !== oldest_word.status || which_i !== oldest_word.which ||
              word_index_i !== oldest_word.idx || word_i !== oldest_word.word ||
              last_i !== oldest_word.last) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: mismatch, expected status %0d which %0d index %0d word %h last %0d",
                       $time, oldest_word.status, oldest_word.which, oldest_word.idx,
                       oldest_word.word, oldest_word.last);
              $display("%0t:           got      status %0d which %0d index %0d word %h last %0d",
                       $time, status_i, which_i, word_index_i, word_i, last_i);
            end
          end
        end
      end
      pending_o = expected_words_q.size();
    end
  end

endmodule

// ----- verif/tb_der_signature_parser.sv -----
`timescale 1ns / 1ps

module tb_der_signature_parser;
  import dsp_pkg::*;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [7:0]          data_byte  = 8'h00;
  logic                sig_start  = 1'b0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [2:0]          status;
  logic                which;
  logic [1:0]          word_index;
  logic [WordBits-1:0] word;
  logic                last;

  int mismatches;
  int pending_words;
  int results;
  int error_results;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int sent_bytes = 0;
  int sig_count  = 0;
  int quota      = 0;

  // {first, byte} pairs for the directed opening
  logic [8:0] directed_seq [23] = '{
    {1'b0, 8'h55},                                    // stray byte while idle
    {1'b1, 8'h31},                                    // bad header
    {1'b1, SeqTag}, {1'b0, 8'h04}, {1'b0, IntTag},    // r and s both zero length
    {1'b0, 8'h00}, {1'b0, IntTag}, {1'b0, 8'h00},
    {1'b1, SeqTag}, {1'b0, 8'h06}, {1'b0, 8'h05},     // bad r marker
    {1'b1, SeqTag}, {1'b0, 8'hFF},                    // abandoned by a new first byte
    {1'b1, SeqTag}, {1'b0, 8'h07}, {1'b0, IntTag}, {1'b0, 8'h22},  // r too long
    {1'b1, SeqTag}, {1'b0, 8'h05}, {1'b0, IntTag},    // bad s marker
    {1'b0, 8'h00}, {1'b0, 8'h04},
    {1'b1, 8'h00}                                     // bad header, all zero
  };

  der_signature_parser i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .first_i      (sig_start),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .which_o      (which),
    .word_index_o (word_index),
    .word_o       (word),
    .last_o       (last)
  );

  der_signature_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .data_byte_i      (data_byte),
    .first_i          (sig_start),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .which_i          (which),
    .word_index_i     (word_index),
    .word_i           (word),
    .last_i           (last),
    .mismatch_count_o (mismatches),
    .pending_o        (pending_words),
    .results_o        (results),
    .error_results_o  (error_results)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send_byte(input logic [8:0] item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    sig_start = item[8];
    data_byte = item[7:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_for_results(input int guard);
    in_valid = 1'b0;
    for (int n = 0; n < guard && pending_words != 0; n++) @(negedge clk);
  endtask

  // mostly short integers, with the empty and longest legal ones now and then
  function automatic int pick_int_len();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 12) return MaxIntBytesDef;
    if (r < 18) return $urandom_range(MaxIntBytesDef);
    return $urandom_range(4);
  endfunction

  task automatic send_signature();
    logic [8:0] seq [$];
    logic [7:0] total;
    logic [7:0] hdr;
    int         kind;
    int         rl;
    int         sl;
    int         cut;
    kind  = $urandom_range(99);
    rl    = pick_int_len();
    sl    = pick_int_len();
    total = 8'(rl + sl + HdrBytes);
    cut   = -1;
    seq.push_back({1'b1, SeqTag});
    seq.push_back({1'b0, total});
    seq.push_back({1'b0, IntTag});
    seq.push_back({1'b0, 8'(rl)});
    for (int i = 0; i < rl; i++) seq.push_back({1'b0, 8'($urandom_range(255))});
    seq.push_back({1'b0, IntTag});
    seq.push_back({1'b0, 8'(sl)});
    for (int i = 0; i < sl; i++) seq.push_back({1'b0, 8'($urandom_range(255))});

    if (kind >= 70 && kind < 80) begin
      seq[1] = {1'b0, total + 8'($urandom_range(1, 255))};
    end else if (kind >= 80 && kind < 84) begin
      hdr = 8'($urandom_range(255));
      if (hdr == SeqTag) hdr = hdr ^ 8'h01;
      seq[0] = {1'b1, hdr};
      cut = 0;
    end else if (kind >= 84 && kind < 90) begin
      cut = $urandom_range(1) ? 2 : 4 + rl;
      seq[cut] = {1'b0, IntTag ^ 8'($urandom_range(1, 255))};
    end else if (kind >= 90 && kind < 95) begin
      cut = $urandom_range(1) ? 3 : 5 + rl;
      seq[cut] = {1'b0, 8'($urandom_range(MaxIntBytesDef + 1, 255))};
    end else if (kind >= 95) begin
      // drop the tail; the next first byte abandons this one
      cut = $urandom_range(seq.size() - 2);
    end
    if (cut >= 0)
      while (seq.size() > cut + 1) void'(seq.pop_back());

    foreach (seq[i]) send_byte(seq[i]);
    sent_bytes += seq.size();
    sig_count++;

    // stray bytes between signatures, not counted
    if ($urandom_range(19) == 0)
      repeat ($urandom_range(1, 3)) send_byte({1'b0, 8'($urandom_range(255))});
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_seq[i]) send_byte(directed_seq[i]);
    sent_bytes += $size(directed_seq);
    wait_for_results(5000);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      quota = sent_bytes + 100;
      while (sent_bytes < quota) send_signature();
      // hold the sender until every expected result is out, or the guard runs out
      wait_for_results(5000);
    end

    stall_pct = 0;
    wait_for_results(20000);
    repeat (20) @(negedge clk);

    $display("Sent %0d bytes: a directed set and %0d random signatures, under four idle mixes.",
             sent_bytes, sig_count);
    $display("Checked %0d results, %0d of them error results; %0d still outstanding.",
             results, error_results, pending_words);
    if (mismatches == 0 && pending_words == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
